// ===== sv/mcbp_pkg.sv =====
// Package for the multi-channel byte pipe: command and status codes, default sizes,
// and the result record passed from the pipe controller to the output stage.
// No dependencies; compiled first.
package mcbp_pkg;

  localparam int unsigned NUM_PIPES_DEF  = 4;
  localparam int unsigned PIPE_BYTES_DEF = 8;

  // Command codes on the request channel.
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Status codes on the response channel.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PIPE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // Everything about one response except the byte that comes from the store.
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] granted_pipe;
    logic [3:0] fill_count;
    logic       read_hit;
    logic       last;
  } meta_t;

endpackage

// ===== sv/mcbp_if.sv =====
// Handshake interfaces for the request and response channels of the byte pipe.
// Depends on nothing; compiled after mcbp_pkg.
interface mcbp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] pipe_id;
  logic [7:0] write_byte;
  logic       request_last;

  modport source (output valid, cmd, pipe_id, write_byte, request_last, input ready);
  modport sink   (input valid, cmd, pipe_id, write_byte, request_last, output ready);
endinterface

interface mcbp_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] granted_pipe;
  logic [7:0] read_byte;
  logic [3:0] fill_count;
  logic       last;

  modport source (output valid, status, granted_pipe, read_byte, fill_count, last,
                  input ready);
  modport sink   (input valid, status, granted_pipe, read_byte, fill_count, last,
                  output ready);
endinterface

// ===== sv/multi_channel_byte_pipe.sv =====
// A table of NUM_PIPES circular byte FIFOs of PIPE_BYTES bytes each, with allocation.
// Channels: the request channel (req_i) carries one command per item: create a pipe,
// write one byte to a pipe, or read one byte from a pipe. The response channel
// (rsp_o) returns exactly one item per request, in order, with a status, the pipe
// number, the byte read, the pipe's fill count afterwards, and the echoed last flag.
// A taken request is registered in the store-read stage, then in the output register
// that drives rsp_o. Throughput: one item per cycle unless the receiver stalls rsp_o.
// Pointer and count updates for a pipe finish in the cycle the request is taken, and
// the single-port byte store handles one write or one read per cycle, so back-to-back
// commands to the same pipe need no wait.
// Reset: every pipe is empty and free; the byte store is not cleared and needs no
// sweep, since a pipe only ever returns bytes that were written to it.
// Stall: when the receiver holds rsp_o.ready low, the output register keeps its
// item, one more request may sit in the store-read stage, and then req_i.ready
// drops until the output register drains.
// Depends on mcbp_pkg, mcbp_if, mcbp_ctrl and mcbp_mem.
module multi_channel_byte_pipe #(
  parameter int unsigned NUM_PIPES  = mcbp_pkg::NUM_PIPES_DEF,
  parameter int unsigned PIPE_BYTES = mcbp_pkg::PIPE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcbp_req_if.sink   req_i,
  mcbp_rsp_if.source rsp_o
);
  import mcbp_pkg::*;

  localparam int unsigned DEPTH  = NUM_PIPES * PIPE_BYTES;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  meta_t             meta;
  logic              accept;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_rdata;

  logic  s1_valid_q;
  meta_t s1_meta_q;
  logic  s1_advance;

  logic       out_valid_q;
  meta_t      out_meta_q;
  logic [7:0] out_byte_q;

  assign s1_advance  = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_advance;
  assign accept      = req_i.valid && req_i.ready;

  mcbp_ctrl #(
    .NUM_PIPES  (NUM_PIPES),
    .PIPE_BYTES (PIPE_BYTES),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cmd_i          (req_i.cmd),
    .pipe_id_i      (req_i.pipe_id),
    .request_last_i (req_i.request_last),
    .meta_o         (meta),
    .mem_we_o       (mem_we),
    .mem_re_o       (mem_re),
    .mem_addr_o     (mem_addr)
  );

  mcbp_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (req_i.write_byte),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
    end
    if (s1_advance) begin
      out_meta_q <= s1_meta_q;
      out_byte_q <= s1_meta_q.read_hit ? mem_rdata : 8'd0;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_meta_q.status;
  assign rsp_o.granted_pipe = out_meta_q.granted_pipe;
  assign rsp_o.read_byte    = out_byte_q;
  assign rsp_o.fill_count   = out_meta_q.fill_count;
  assign rsp_o.last         = out_meta_q.last;

endmodule

// ===== sv/mcbp_mem.sv =====
// Byte store shared by all pipes: one write or one registered read per cycle.
// Depends on nothing; instantiated by the top level.
module mcbp_mem #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [7:0]        wdata_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Read data holds between reads so a stalled response keeps its byte.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mcbp_ctrl.sv =====
// Pipe controller: head, tail, count and busy flag of every pipe, command decode,
// allocation, and the store access for each accepted item. Uses mcbp_pkg.
module mcbp_ctrl #(
  parameter int unsigned NUM_PIPES  = 4,
  parameter int unsigned PIPE_BYTES = 8,
  parameter int unsigned ADDR_W     = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          cmd_i,
  input  logic [1:0]          pipe_id_i,
  input  logic                request_last_i,
  output mcbp_pkg::meta_t     meta_o,
  output logic                mem_we_o,
  output logic                mem_re_o,
  output logic [ADDR_W-1:0]   mem_addr_o
);
  import mcbp_pkg::*;

  localparam int unsigned PIPE_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int unsigned PTR_W  = $clog2(PIPE_BYTES);
  localparam int unsigned CNT_W  = $clog2(PIPE_BYTES + 1);
  localparam logic [PTR_W-1:0]  PtrLast  = PTR_W'(PIPE_BYTES - 1);
  localparam logic [CNT_W-1:0]  CntFull  = CNT_W'(PIPE_BYTES);
  localparam logic [ADDR_W-1:0] PipeSpan = ADDR_W'(PIPE_BYTES);

  logic [PTR_W-1:0] head_q  [NUM_PIPES];
  logic [PTR_W-1:0] tail_q  [NUM_PIPES];
  logic [CNT_W-1:0] count_q [NUM_PIPES];
  logic [NUM_PIPES-1:0] busy_q;

  logic              pid_ok;
  logic [PIPE_W-1:0] pid;
  logic [PTR_W-1:0]  cur_head;
  logic [PTR_W-1:0]  cur_tail;
  logic [CNT_W-1:0]  cur_count;
  logic              free_found;
  logic [PIPE_W-1:0] free_idx;
  logic              do_alloc;
  logic              do_write;
  logic              do_read;
  logic [PTR_W-1:0]  ptr_sel;

  assign pid_ok    = 32'(pipe_id_i) < NUM_PIPES;
  assign pid       = PIPE_W'(pipe_id_i);
  assign cur_head  = head_q[pid];
  assign cur_tail  = tail_q[pid];
  assign cur_count = count_q[pid];

  // Lowest-numbered free pipe.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = PIPE_W'(i);
      end
    end
  end

  always_comb begin
    meta_o.status       = ST_OK;
    meta_o.granted_pipe = pipe_id_i;
    meta_o.fill_count   = pid_ok ? 4'(cur_count) : 4'd0;
    meta_o.read_hit     = 1'b0;
    meta_o.last         = request_last_i;
    do_alloc = 1'b0;
    do_write = 1'b0;
    do_read  = 1'b0;
    case (cmd_i)
      CMD_CREATE: begin
        meta_o.fill_count = 4'd0;
        if (free_found) begin
          do_alloc            = 1'b1;
          meta_o.granted_pipe = 2'(free_idx);
          meta_o.fill_count   = 4'(count_q[free_idx]);
        end else begin
          meta_o.status = ST_NO_PIPE;
        end
      end
      CMD_WRITE: begin
        if (!pid_ok || cur_count == CntFull) begin
          meta_o.status = ST_FULL;
        end else begin
          do_write          = 1'b1;
          meta_o.fill_count = 4'(cur_count + 1'b1);
        end
      end
      CMD_READ: begin
        if (!pid_ok || cur_count == '0) begin
          meta_o.status = ST_EMPTY;
        end else begin
          do_read           = 1'b1;
          meta_o.read_hit   = 1'b1;
          meta_o.fill_count = 4'(cur_count - 1'b1);
        end
      end
      default: ;
    endcase
  end

  assign ptr_sel    = do_write ? cur_head : cur_tail;
  assign mem_addr_o = ADDR_W'(pid) * PipeSpan + ADDR_W'(ptr_sel);
  assign mem_we_o   = accept_i && do_write;
  assign mem_re_o   = accept_i && do_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      for (int i = 0; i < NUM_PIPES; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (accept_i) begin
      if (do_alloc) begin
        busy_q[free_idx] <= 1'b1;
      end
      if (do_write) begin
        head_q[pid]  <= (cur_head == PtrLast) ? '0 : cur_head + 1'b1;
        count_q[pid] <= cur_count + 1'b1;
      end
      if (do_read) begin
        tail_q[pid]  <= (cur_tail == PtrLast) ? '0 : cur_tail + 1'b1;
        count_q[pid] <= cur_count - 1'b1;
      end
    end
  end

endmodule

// ===== test/multi_channel_byte_pipe_checker.sv =====
`timescale 1ns / 100ps
// Checker for multi_channel_byte_pipe. It watches the request and response channels
// and keeps its own pipe table to predict each response. It counts mismatches.
// Depends on mcbp_pkg and on the mcbp_req_if and mcbp_rsp_if interfaces.
module multi_channel_byte_pipe_checker #(
  parameter int unsigned NUM_PIPES  = mcbp_pkg::NUM_PIPES_DEF,
  parameter int unsigned PIPE_BYTES = mcbp_pkg::PIPE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcbp_req_if        req_i,
  mcbp_rsp_if        rsp_i,
  output int         mismatches_o,
  output int         pending_o
);
  import mcbp_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] granted_pipe;
    logic [7:0] read_byte;
    logic [3:0] fill_count;
    logic       last;
  } pipe_rsp_t;

  pipe_rsp_t   rsp_expected_q[$];
  pipe_rsp_t   rsp_want;
  logic [7:0]  pipe_bytes [NUM_PIPES][PIPE_BYTES];
  int unsigned head_ptr   [NUM_PIPES];
  int unsigned tail_ptr   [NUM_PIPES];
  int unsigned pipe_level [NUM_PIPES];
  bit          pipe_busy  [NUM_PIPES];

  function automatic int unsigned next_slot(int unsigned ptr);
    return (ptr + 1 >= PIPE_BYTES) ? 0 : ptr + 1;
  endfunction

  // Applies one command to the pipe table and returns the response it must produce.
  function automatic pipe_rsp_t apply_pipe_cmd(logic [1:0] cmd, logic [1:0] pid,
                                               logic [7:0] data, logic req_last);
    pipe_rsp_t rsp;
    bit        found;
    bit        pid_ok;
    rsp.status       = ST_OK;
    rsp.granted_pipe = pid;
    rsp.read_byte    = 8'h00;
    rsp.fill_count   = 4'd0;
    rsp.last         = req_last;
    pid_ok           = pid < NUM_PIPES;
    found            = 1'b0;
    case (cmd)
      CMD_CREATE: begin
        for (int p = 0; p < NUM_PIPES; p++) begin
          if (!found && !pipe_busy[p]) begin
            pipe_busy[p]     = 1'b1;
            rsp.granted_pipe = 2'(p);
            rsp.fill_count   = 4'(pipe_level[p]);
            found            = 1'b1;
          end
        end
        if (!found) rsp.status = ST_NO_PIPE;
      end
      CMD_WRITE: begin
        if (!pid_ok || pipe_level[pid] >= PIPE_BYTES) begin
          rsp.status = ST_FULL;
        end else begin
          pipe_bytes[pid][head_ptr[pid]] = data;
          head_ptr[pid]                  = next_slot(head_ptr[pid]);
          pipe_level[pid]++;
        end
        if (pid_ok) rsp.fill_count = 4'(pipe_level[pid]);
      end
      CMD_READ: begin
        if (!pid_ok || pipe_level[pid] == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.read_byte = pipe_bytes[pid][tail_ptr[pid]];
          tail_ptr[pid] = next_slot(tail_ptr[pid]);
          pipe_level[pid]--;
        end
        if (pid_ok) rsp.fill_count = 4'(pipe_level[pid]);
      end
      default: begin
        // The spare command code does nothing but report the pipe's level.
        if (pid_ok) rsp.fill_count = 4'(pipe_level[pid]);
      end
    endcase
    return rsp;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches_o++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PIPES; p++) begin
        head_ptr[p]   = 0;
        tail_ptr[p]   = 0;
        pipe_level[p] = 0;
        pipe_busy[p]  = 1'b0;
      end
      rsp_expected_q.delete();
      mismatches_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (rsp_expected_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: response expected none, actual status %0d pipe %0d byte %0d fill %0d",
                   $time, rsp_i.status, rsp_i.granted_pipe, rsp_i.read_byte,
                   rsp_i.fill_count);
        end else begin
          rsp_want = rsp_expected_q.pop_front();
          check_field("status", rsp_want.status, rsp_i.status);
          check_field("granted_pipe", rsp_want.granted_pipe, rsp_i.granted_pipe);
          check_field("read_byte", rsp_want.read_byte, rsp_i.read_byte);
          check_field("fill_count", rsp_want.fill_count, rsp_i.fill_count);
          check_field("last", rsp_want.last, rsp_i.last);
        end
      end
      if (req_i.valid && req_i.ready) begin
        rsp_expected_q.push_back(apply_pipe_cmd(req_i.cmd, req_i.pipe_id,
                                                req_i.write_byte, req_i.request_last));
      end
    end
    pending_o = rsp_expected_q.size();
  end

endmodule

// ===== test/multi_channel_byte_pipe_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for multi_channel_byte_pipe: drives pipe commands with random gaps and
// response stalls, and reports the verdict from the checker's mismatch and pending counts.
// Depends on mcbp_pkg, the mcbp interfaces, the block and multi_channel_byte_pipe_checker.
module multi_channel_byte_pipe_tb;
  import mcbp_pkg::*;

  // The one command code the block leaves unused.
  localparam logic [1:0] CMD_NONE    = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_left;
  int   mismatches;
  int   pending;
  int   cycles;

  mcbp_req_if req_if ();
  mcbp_rsp_if rsp_if ();

  multi_channel_byte_pipe dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  multi_channel_byte_pipe_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_channel_byte_pipe: mismatch");
      $finish;
    end
  end

  // Response side: a long hold-off counts down here, otherwise ready stalls at random.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one item and returns at the edge where it is taken.
  task automatic send_cmd(logic [1:0] cmd, logic [1:0] pid, logic [7:0] data,
                          logic req_last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        = 1'b1;
    req_if.cmd          = cmd;
    req_if.pipe_id      = pid;
    req_if.write_byte   = data;
    req_if.request_last = req_last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Bursts of sixteen items lean on one pipe, either filling or emptying it, so that
  // full and empty both come up often.
  task automatic run_random(int n_items);
    int unsigned focus;
    int unsigned write_pct;
    int unsigned pick;
    logic [1:0]  cmd;
    logic [1:0]  pid;
    for (int i = 0; i < n_items; i++) begin
      if (i % 16 == 0) begin
        focus     = $urandom_range(NUM_PIPES_DEF - 1);
        write_pct = $urandom_range(1) ? 70 : 20;
      end
      pick = $urandom_range(99);
      if (pick < 6) cmd = CMD_CREATE;
      else if (pick < 12) cmd = CMD_NONE;
      else if (pick < 12 + write_pct) cmd = CMD_WRITE;
      else cmd = CMD_READ;
      pid = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'(focus);
      send_cmd(cmd, pid, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [7:0] pattern [8];
    pattern             = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFE};
    req_if.valid        = 1'b0;
    req_if.cmd          = CMD_CREATE;
    req_if.pipe_id      = 2'd0;
    req_if.write_byte   = 8'h00;
    req_if.request_last = 1'b0;
    rst_ni              = 1'b0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    hold_left           = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Read and write a pipe before it is allocated, so the first create sees a byte in it.
    send_cmd(CMD_READ, 2'd0, 8'h00, 1'b0);
    send_cmd(CMD_WRITE, 2'd0, 8'hA5, 1'b1);
    for (int p = 0; p < 4; p++) send_cmd(CMD_CREATE, 2'(p), 8'h00, 1'b0);
    send_cmd(CMD_CREATE, 2'd3, 8'h00, 1'b1);
    // Fill pipe 2 past its depth, then drain it past empty; both pointers wrap.
    for (int k = 0; k < 9; k++) send_cmd(CMD_WRITE, 2'd2, pattern[k % 8], 1'(k == 7));
    send_cmd(CMD_NONE, 2'd2, 8'hFF, 1'b1);
    send_cmd(CMD_NONE, 2'd0, 8'h00, 1'b0);
    for (int k = 0; k < 9; k++) send_cmd(CMD_READ, 2'd2, 8'h00, 1'(k == 8));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      run_random(290);
      wait_drained();
    end

    // Hold the response side off while items keep coming, so the block backs up.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 80;
    run_random(40);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("multi_channel_byte_pipe: match");
    end else begin
      $display("multi_channel_byte_pipe: mismatch");
    end
    $finish;
  end

endmodule
